// ----- src/stbs_pkg.sv -----
// shared constants, action codes and control/status types for the bound search block
package stbs_pkg;

    // default geometry
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BITS    = 32;

    // transaction action codes
    localparam int ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ABOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BELOW = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic write;
        logic check;
        logic step;
        logic last;
        logic emit;
    } stbs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic exit_now;
        logic narrow;
    } stbs_stat_t;

endpackage

// ----- src/sorted_table_bound_search.sv -----
// top level of the sorted key table with lower and upper bound search
//
// usage:
//   a transaction is taken at a rising edge with start high and busy low.
//   action selects a table write (key_value stored at entry_index), a search
//   for the first entry at or above key_value, or for the last entry at or
//   below key_value, over the first table_length entries.
//   writes finish in the accepting cycle, leave busy low and give no result.
//   a search raises busy and ends with done high for exactly one cycle,
//   found_index holding the answer (the length, capped at TABLE_DEPTH, or -1 when there is none).
//   the search is paced by the single table read port: one probe per cycle,
//   registered read data compared and next address formed. an empty table, or
//   a key past the last entry (at or above) or before the first entry (at or
//   below), answers from the first check without any bisection step.
//   the receiver cannot stall; done is a strobe and the next transaction may
//   be started in the cycle done is shown.
//   cfg_write loads table_length; write it only while idle.
//   reset sets table_length to 1 and the controller to idle; table contents
//   are undefined until written and need no clearing pass.
module sorted_table_bound_search #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = stbs_pkg::DEF_KEY_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [stbs_pkg::ACTION_W-1:0]         action,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        entry_index,
    input  logic signed [KEY_BITS-1:0]            key_value,
    input  logic                                  cfg_write,
    input  logic [$clog2(TABLE_DEPTH):0]          table_length,
    output logic                                  done,
    output logic signed [$clog2(TABLE_DEPTH)+1:0] found_index
);
    import stbs_pkg::*;

    stbs_cmd_t  cmd;
    stbs_stat_t stat;

    // controller
    stbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath
    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .entry_index  (entry_index),
        .key_value    (key_value),
        .cfg_write    (cfg_write),
        .table_length (table_length),
        .found_index  (found_index)
    );

endmodule

// ----- src/stbs_datapath.sv -----
// key table memory, search bounds, probe compare and result register
module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = stbs_pkg::DEF_KEY_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  stbs_pkg::stbs_cmd_t                   cmd,
    output stbs_pkg::stbs_stat_t                  stat,
    input  logic [stbs_pkg::ACTION_W-1:0]         action,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        entry_index,
    input  logic signed [KEY_BITS-1:0]            key_value,
    input  logic                                  cfg_write,
    input  logic [$clog2(TABLE_DEPTH):0]          table_length,
    output logic signed [$clog2(TABLE_DEPTH)+1:0] found_index
);
    import stbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W = IDX_W + 1;
    localparam int OUT_W = IDX_W + 2;
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] ONE_IDX   = IDX_W'(1);

    logic [KEY_BITS-1:0]        mem [TABLE_DEPTH];
    logic [LEN_W-1:0]           len_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic                       above_reg;
    logic [LEN_W-1:0]           n_reg;
    logic                       zero_reg;
    logic [IDX_W-1:0]           lo_reg;
    logic [IDX_W-1:0]           hi_reg;
    logic [IDX_W-1:0]           mid_reg;
    logic [KEY_BITS-1:0]        rd_data_reg;
    logic [OUT_W-1:0]           found_reg;

    logic [LEN_W-1:0] n_sat;
    logic [IDX_W-1:0] last_idx;
    logic             in_range;
    logic             cmp_lt;
    logic             cmp_gt;
    logic             early;
    logic [IDX_W-1:0] lo_cand;
    logic [IDX_W-1:0] hi_cand;
    logic [IDX_W-1:0] diff;
    logic [IDX_W-1:0] mid_cand;
    logic [IDX_W-1:0] fin_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [OUT_W-1:0] chk_ans;
    logic [OUT_W-1:0] fin_ans;

    // length register, reset to one entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            len_reg <= table_length;
        end
    end

    // effective length and top index
    assign n_sat    = (len_reg > DEPTH_LEN) ? DEPTH_LEN : len_reg;
    assign last_idx = (n_sat == '0) ? '0 : IDX_W'(n_sat - LEN_W'(1));
    assign in_range = ({1'b0, entry_index} < DEPTH_LEN);

    // probe compare against the search key
    assign cmp_lt = ($signed(rd_data_reg) < key_reg);
    assign cmp_gt = ($signed(rd_data_reg) > key_reg);
    assign early  = above_reg ? cmp_lt : cmp_gt;

    // next bounds: initial interval on the check, bisection step otherwise
    always_comb
    begin
        lo_cand = lo_reg;
        hi_cand = hi_reg;
        if (cmd.check)
        begin
            lo_cand = '0;
            hi_cand = IDX_W'(n_reg - LEN_W'(1));
        end
        else if (above_reg)
        begin
            if (cmp_lt)
            begin
                lo_cand = mid_reg;
            end
            else
            begin
                hi_cand = mid_reg;
            end
        end
        else
        begin
            if (cmp_gt)
            begin
                hi_cand = mid_reg;
            end
            else
            begin
                lo_cand = mid_reg;
            end
        end
    end

    // next probe address
    assign diff     = hi_cand - lo_cand;
    assign mid_cand = above_reg ? (lo_cand + (diff >> 1)) : (hi_cand - (diff >> 1));
    assign fin_addr = above_reg ? lo_cand : hi_cand;

    always_comb
    begin
        if (cmd.check || cmd.step)
        begin
            rd_addr = (diff <= ONE_IDX) ? fin_addr : mid_cand;
        end
        else
        begin
            rd_addr = (action == ACT_ABOVE) ? last_idx : '0;
        end
    end

    assign stat.exit_now = zero_reg || early;
    assign stat.narrow   = (diff <= ONE_IDX);

    // answers: early exit / empty table, and after the last probe
    always_comb
    begin
        if (above_reg)
        begin
            chk_ans = zero_reg ? '0 : OUT_W'(n_reg);
            fin_ans = cmp_lt ? OUT_W'(hi_reg) : OUT_W'(lo_reg);
        end
        else
        begin
            chk_ans = '1;
            fin_ans = cmp_gt ? OUT_W'(lo_reg) : OUT_W'(hi_reg);
        end
    end

    // table write port
    always_ff @(posedge clk)
    begin
        if (cmd.write && in_range)
        begin
            mem[entry_index] <= key_value;
        end
    end

    // table read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // search context and bounds
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= key_value;
            above_reg <= (action == ACT_ABOVE);
            n_reg     <= n_sat;
            zero_reg  <= (n_sat == '0);
        end
        if (cmd.check || cmd.step)
        begin
            lo_reg  <= lo_cand;
            hi_reg  <= hi_cand;
            mid_reg <= mid_cand;
        end
        if (cmd.emit)
        begin
            found_reg <= cmd.last ? fin_ans : chk_ans;
        end
    end

    assign found_index = $signed(found_reg);

    // bisection keeps at least three candidates while stepping
    a_step_width: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ((hi_reg - lo_reg) > ONE_IDX))
        else $error("step with interval too narrow");

    // probe lies strictly inside the interval
    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (mid_reg > lo_reg && mid_reg < hi_reg))
        else $error("probe outside interval");

    // loaded length never exceeds the table
    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (n_reg <= DEPTH_LEN))
        else $error("search length beyond table depth");

endmodule

// ----- src/stbs_ctrl.sv -----
// controller state machine sequencing writes and bound searches
module stbs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [stbs_pkg::ACTION_W-1:0] action,
    input  stbs_pkg::stbs_stat_t          stat,
    output stbs_pkg::stbs_cmd_t           cmd,
    output logic                          busy,
    output logic                          done
);
    import stbs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_LAST  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else if (action == ACT_ABOVE || action == ACT_BELOW)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.exit_now)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = stat.narrow ? S_LAST : S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.narrow ? S_LAST : S_STEP;
            end
            S_LAST:
            begin
                cmd.last   = 1'b1;
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.emit;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // a result is shown only once the search has ended
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still searching");

    // a result always follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a search");

    // an accepted search occupies the block
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_ABOVE || action == ACT_BELOW)) |=> busy)
        else $error("search transaction dropped");

endmodule

// ----- dv/sorted_table_bound_search_tb.sv -----
// testbench for the sorted key table with first-at-or-above and last-at-or-below search
module sorted_table_bound_search_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int DEPTH   = DEF_TABLE_DEPTH;
    localparam int KEY_W   = DEF_KEY_BITS;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int LEN_W   = IDX_W + 1;
    localparam int BOUND_W = IDX_W + 2;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam int LEN_MAX       = (1 << LEN_W) - 1;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 60;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [ACTION_W-1:0]        action;
    logic [IDX_W-1:0]           entry_index;
    logic signed [KEY_W-1:0]    key_value;
    logic                       cfg_write;
    logic [LEN_W-1:0]           table_length;
    logic                       done;
    logic signed [BOUND_W-1:0]  found_index;

    // shadow copy of the block state
    logic signed [KEY_W-1:0]    shadow_keys [DEPTH];
    logic [LEN_W-1:0]           shadow_length;
    logic signed [BOUND_W-1:0]  pending_bounds [$];
    logic signed [BOUND_W-1:0]  oldest_bound;

    int errors;
    int items_sent;
    int burst_left;
    int idle_cycles;

    sorted_table_bound_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .entry_index  (entry_index),
        .key_value    (key_value),
        .cfg_write    (cfg_write),
        .table_length (table_length),
        .done         (done),
        .found_index  (found_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // bisection over the shadow table, same probe order as the block
    function automatic logic signed [BOUND_W-1:0] bound_of(input logic [ACTION_W-1:0] act,
                                                          input logic signed [KEY_W-1:0] key);
        int n;
        int lo;
        int hi;
        int mid;
        n = (shadow_length > DEPTH) ? DEPTH : int'(shadow_length);
        if (n == 0)
            return (act == ACT_ABOVE) ? BOUND_W'(0) : -BOUND_W'(1);
        lo = 0;
        hi = n - 1;
        if (act == ACT_ABOVE)
        begin
            if (key > shadow_keys[hi])
                return BOUND_W'(n);
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (mid == lo)
                    break;
                if (shadow_keys[mid] < key)
                    lo = mid;
                else
                    hi = mid;
            end
            if (shadow_keys[lo] >= key)
                hi = lo;
            return BOUND_W'(hi);
        end
        if (key < shadow_keys[0])
            return -BOUND_W'(1);
        while (lo < hi)
        begin
            mid = hi - (hi - lo) / 2;
            if (mid == hi)
                break;
            if (shadow_keys[mid] > key)
                hi = mid;
            else
                lo = mid;
        end
        if (shadow_keys[hi] <= key)
            lo = hi;
        return BOUND_W'(lo);
    endfunction

    // search key at or next to a table entry, near zero, at the extremes or anywhere
    function automatic logic signed [KEY_W-1:0] pick_key();
        int n;
        int near;
        logic signed [KEY_W-1:0] probe;
        n = (shadow_length > DEPTH) ? DEPTH : int'(shadow_length);
        if (n == 0)
            n = 1;
        probe = shadow_keys[$urandom_range(0, n - 1)];
        near = int'($urandom_range(0, 20)) - 10;
        case ($urandom_range(0, 6))
            0: return probe;
            1: return probe + 1;
            2: return probe - 1;
            3: return $urandom;
            4: return KEY_MIN;
            5: return KEY_MAX;
            default: return near;
        endcase
    endfunction

    // drive one transaction after a random gap and update the shadow on accept
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [IDX_W-1:0] idx,
                             input logic signed [KEY_W-1:0] key);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(10, 30);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        action      <= act;
        entry_index <= idx;
        key_value   <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (act == ACT_WRITE)
            shadow_keys[idx] = key;
        else if (act == ACT_ABOVE || act == ACT_BELOW)
            pending_bounds.push_back(bound_of(act, key));
        items_sent++;
    endtask

    // drop start and let every outstanding search finish
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_bounds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(input int len);
        wait_idle();
        @(negedge clk);
        cfg_write     <= 1'b1;
        table_length  <= LEN_W'(len);
        shadow_length = LEN_W'(len);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // fill entries 0..n-1 with ascending keys, dense duplicates to wide steps
    task automatic load_sorted_table(input int n);
        logic signed [KEY_W-1:0] vals [DEPTH];
        longint level;
        longint stride;
        int i;
        case ($urandom_range(0, 2))
            0: stride = 2;
            1: stride = 1000;
            default: stride = 1 << 28;
        endcase
        if ($urandom_range(0, 3) == 0)
            level = longint'(KEY_MIN);
        else
            level = longint'($signed($urandom));
        for (i = 0; i < n; i++)
        begin
            if (level > longint'(KEY_MAX))
                level = longint'(KEY_MAX);
            vals[i] = KEY_W'(level);
            level += longint'($urandom_range(0, int'(stride)));
        end
        if ($urandom_range(0, 1) == 0)
        begin
            for (i = 0; i < n; i++)
                send_item(ACT_WRITE, IDX_W'(i), vals[i]);
        end
        else
        begin
            for (i = n - 1; i >= 0; i--)
                send_item(ACT_WRITE, IDX_W'(i), vals[i]);
        end
    endtask

    // reset length of one entry, and the unused action
    task automatic test_reset_length();
        send_item(ACT_UNUSED, '1, KEY_MAX);
        send_item(ACT_WRITE, '0, 32'sd5);
        send_item(ACT_ABOVE, '0, 32'sd5);
        send_item(ACT_ABOVE, '0, 32'sd6);
        send_item(ACT_BELOW, '0, 32'sd4);
        send_item(ACT_BELOW, '0, 32'sd5);
    endtask

    // empty table answers from the length alone, whatever the entries hold
    task automatic test_empty_table();
        set_length(0);
        send_item(ACT_ABOVE, '0, KEY_MAX);
        send_item(ACT_BELOW, '0, KEY_MIN);
        send_item(ACT_ABOVE, '1, KEY_MIN);
        send_item(ACT_BELOW, '1, KEY_MAX);
    endtask

    // extreme key values in the table and as search keys
    task automatic test_extreme_keys();
        set_length(4);
        send_item(ACT_WRITE, IDX_W'(0), KEY_MIN);
        send_item(ACT_WRITE, IDX_W'(1), -32'sd1);
        send_item(ACT_WRITE, IDX_W'(2), 32'sd0);
        send_item(ACT_WRITE, IDX_W'(3), KEY_MAX);
        send_item(ACT_WRITE, '1, -32'sd1);
        send_item(ACT_ABOVE, '0, KEY_MIN);
        send_item(ACT_BELOW, '0, KEY_MAX);
        send_item(ACT_ABOVE, '0, KEY_MAX);
        send_item(ACT_BELOW, '0, KEY_MIN);
        send_item(ACT_ABOVE, '0, 32'sd1);
        send_item(ACT_BELOW, '0, -32'sd2);
    endtask

    // random short tables, searches mixed with stray writes and unused actions
    task automatic test_random_tables();
        int first_item;
        int len;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            set_length(len);
            load_sorted_table(len);
            repeat ($urandom_range(8, 40))
            begin
                case ($urandom_range(0, 9))
                    // stray write, may break the ordering
                    0: send_item(ACT_WRITE, IDX_W'($urandom), $urandom);
                    1: send_item(ACT_UNUSED, IDX_W'($urandom), $urandom);
                    default: send_item($urandom_range(0, 1) ? ACT_ABOVE : ACT_BELOW,
                                       IDX_W'($urandom), pick_key());
                endcase
            end
        end
    endtask

    // whole table, then lengths beyond the depth that saturate
    task automatic test_full_table();
        set_length(DEPTH);
        load_sorted_table(DEPTH);
        repeat (40)
            send_item($urandom_range(0, 1) ? ACT_ABOVE : ACT_BELOW, IDX_W'($urandom),
                      pick_key());
        set_length(DEPTH + 1);
        repeat (15)
            send_item($urandom_range(0, 1) ? ACT_ABOVE : ACT_BELOW, IDX_W'($urandom),
                      pick_key());
        set_length(LEN_MAX);
        repeat (15)
            send_item($urandom_range(0, 1) ? ACT_ABOVE : ACT_BELOW, IDX_W'($urandom),
                      pick_key());
    endtask

    // compare each result strobe with the oldest expected bound
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_bounds.size() == 0)
            begin
                $display("%0t: found_index expected none actual %0d", $time, found_index);
                errors++;
            end
            else
            begin
                oldest_bound = pending_bounds.pop_front();
                if (found_index !== oldest_bound)
                begin
                    $display("%0t: found_index expected %0d actual %0d",
                             $time, oldest_bound, found_index);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction, result or register write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        action        = ACT_WRITE;
        entry_index   = '0;
        key_value     = '0;
        cfg_write     = 1'b0;
        table_length  = LEN_W'(1);
        shadow_length = LEN_W'(1);
        errors        = 0;
        items_sent    = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        foreach (shadow_keys[i])
            shadow_keys[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_length();
        test_empty_table();
        test_extreme_keys();
        test_random_tables();
        test_full_table();
        wait_idle();

        if (pending_bounds.size() != 0)
        begin
            $display("%0t: found_index expected %0d actual none (%0d results missing)",
                     $time, pending_bounds[0], pending_bounds.size());
            errors++;
        end
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
